// ----- design/fjot_pkg.sv -----
// ----------------------------------------------------------------------------
// fjot_pkg
// Shared types, character codes and helpers for the flat JSON object tokenizer.
// ----------------------------------------------------------------------------
package fjot_pkg;

    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_ACCEPTED = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_WAIT_OPEN  = 4'd0,
        PH_AFTER_OPEN = 4'd1,
        PH_KEY        = 4'd2,
        PH_KEY_ESC    = 4'd3,
        PH_AFTER_KEY  = 4'd4,
        PH_BEFORE_VAL = 4'd5,
        PH_VSTR       = 4'd6,
        PH_VSTR_ESC   = 4'd7,
        PH_BARE       = 4'd8,
        PH_AFTER_VAL  = 4'd9,
        PH_NEXT_KEY   = 4'd10,
        PH_ACCEPTED   = 4'd11,
        PH_REJECTED   = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        CC_OPEN,
        CC_CLOSE,
        CC_COLON,
        CC_COMMA,
        CC_QUOTE,
        CC_BSLASH,
        CC_WS,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        logic [7:0]  raw;
        logic [7:0]  esc;
        char_class_t cls;
        logic        last;
    } tok_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r = CC_OTHER;
        if (c == CH_OPEN)
            r = CC_OPEN;
        else if (c == CH_CLOSE)
            r = CC_CLOSE;
        else if (c == CH_COLON)
            r = CC_COLON;
        else if (c == CH_COMMA)
            r = CC_COMMA;
        else if (c == CH_QUOTE)
            r = CC_QUOTE;
        else if (c == CH_BSLASH)
            r = CC_BSLASH;
        else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            r = CC_WS;
        return r;
    endfunction

endpackage

// ----- design/fjot_front.sv -----
// ----------------------------------------------------------------------------
// fjot_front
// Input side: classifies each incoming beat and resolves its escape byte.
// ----------------------------------------------------------------------------
module fjot_front
(
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,    // [7:0] in_byte
    input  logic           s_tlast,
    output logic           push,
    output fjot_pkg::tok_t push_tok,
    input  logic           q_full
);

    assign s_tready      = !q_full;
    assign push          = s_tvalid && !q_full;
    assign push_tok.raw  = s_tdata;
    assign push_tok.esc  = (s_tdata == fjot_pkg::CH_N) ? fjot_pkg::CH_NL : s_tdata;
    assign push_tok.cls  = fjot_pkg::classify(s_tdata);
    assign push_tok.last = s_tlast;

endmodule

// ----- design/fjot_queue.sv -----
// ----------------------------------------------------------------------------
// fjot_queue
// Short token queue between front and back.
// ----------------------------------------------------------------------------
module fjot_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fjot_pkg::tok_t push_tok,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output fjot_pkg::tok_t q_tok
);

    fjot_pkg::tok_t                 mem [fjot_pkg::QUEUE_DEPTH];
    logic [fjot_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [fjot_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [fjot_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [fjot_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [fjot_pkg::QCNT_W-1:0]    count_reg;
    logic [fjot_pkg::QCNT_W-1:0]    count_next;

    assign full    = (count_reg == fjot_pkg::QCNT_W'(fjot_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_tok   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == fjot_pkg::QPTR_W'(fjot_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == fjot_pkg::QPTR_W'(fjot_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_tok;
    end

endmodule

// ----- design/fjot_back.sv -----
// ----------------------------------------------------------------------------
// fjot_back
// Parse state machine and output register.
// ----------------------------------------------------------------------------
module fjot_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  fjot_pkg::tok_t q_tok,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,    // [7:0] out_byte, [8] key_done, [9] value_done,
                                       // [11:10] status, [15:12] zero
    output logic [1:0]     m_tuser     // [1:0] byte_kind
);

    fjot_pkg::phase_t phase_reg;
    fjot_pkg::phase_t phase_next;
    fjot_pkg::phase_t nx;

    logic [7:0] ob;
    logic [1:0] kind;
    logic       kdone;
    logic       vdone;
    logic [1:0] status;

    logic       m_tvalid_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] kind_reg;
    logic       key_done_reg;
    logic       value_done_reg;
    logic [1:0] status_reg;

    assign pop = q_valid && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        nx    = phase_reg;
        ob    = 8'h00;
        kind  = fjot_pkg::KIND_NONE;
        kdone = 1'b0;
        vdone = 1'b0;
        unique case (phase_reg)
            fjot_pkg::PH_WAIT_OPEN:
            begin
                if (q_tok.cls == fjot_pkg::CC_OPEN)
                    nx = fjot_pkg::PH_AFTER_OPEN;
                else if (q_tok.cls != fjot_pkg::CC_WS)
                    nx = fjot_pkg::PH_REJECTED;
            end
            fjot_pkg::PH_AFTER_OPEN, fjot_pkg::PH_NEXT_KEY:
            begin
                if (q_tok.cls == fjot_pkg::CC_QUOTE)
                    nx = fjot_pkg::PH_KEY;
                else if (q_tok.cls == fjot_pkg::CC_CLOSE
                         && phase_reg == fjot_pkg::PH_AFTER_OPEN)
                    nx = fjot_pkg::PH_ACCEPTED;
                else if (q_tok.cls != fjot_pkg::CC_WS)
                    nx = fjot_pkg::PH_REJECTED;
            end
            fjot_pkg::PH_KEY:
            begin
                if (q_tok.cls == fjot_pkg::CC_BSLASH)
                    nx = fjot_pkg::PH_KEY_ESC;
                else if (q_tok.cls == fjot_pkg::CC_QUOTE)
                begin
                    kdone = 1'b1;
                    nx    = fjot_pkg::PH_AFTER_KEY;
                end
                else
                begin
                    ob   = q_tok.raw;
                    kind = fjot_pkg::KIND_KEY;
                end
            end
            fjot_pkg::PH_KEY_ESC:
            begin
                ob   = q_tok.esc;
                kind = fjot_pkg::KIND_KEY;
                nx   = fjot_pkg::PH_KEY;
            end
            fjot_pkg::PH_AFTER_KEY:
            begin
                if (q_tok.cls == fjot_pkg::CC_COLON)
                    nx = fjot_pkg::PH_BEFORE_VAL;
                else if (q_tok.cls != fjot_pkg::CC_WS)
                    nx = fjot_pkg::PH_REJECTED;
            end
            fjot_pkg::PH_BEFORE_VAL:
            begin
                if (q_tok.cls == fjot_pkg::CC_QUOTE)
                    nx = fjot_pkg::PH_VSTR;
                else if (q_tok.cls == fjot_pkg::CC_COMMA
                         || q_tok.cls == fjot_pkg::CC_CLOSE)
                    nx = fjot_pkg::PH_REJECTED;
                else if (q_tok.cls != fjot_pkg::CC_WS)
                begin
                    ob   = q_tok.raw;
                    kind = fjot_pkg::KIND_VALUE;
                    nx   = fjot_pkg::PH_BARE;
                end
            end
            fjot_pkg::PH_VSTR:
            begin
                if (q_tok.cls == fjot_pkg::CC_BSLASH)
                    nx = fjot_pkg::PH_VSTR_ESC;
                else if (q_tok.cls == fjot_pkg::CC_QUOTE)
                begin
                    vdone = 1'b1;
                    nx    = fjot_pkg::PH_AFTER_VAL;
                end
                else
                begin
                    ob   = q_tok.raw;
                    kind = fjot_pkg::KIND_VALUE;
                end
            end
            fjot_pkg::PH_VSTR_ESC:
            begin
                ob   = q_tok.esc;
                kind = fjot_pkg::KIND_VALUE;
                nx   = fjot_pkg::PH_VSTR;
            end
            fjot_pkg::PH_BARE:
            begin
                if (q_tok.cls == fjot_pkg::CC_COMMA)
                begin
                    vdone = 1'b1;
                    nx    = fjot_pkg::PH_NEXT_KEY;
                end
                else if (q_tok.cls == fjot_pkg::CC_CLOSE)
                begin
                    vdone = 1'b1;
                    nx    = fjot_pkg::PH_ACCEPTED;
                end
                else if (q_tok.cls == fjot_pkg::CC_WS)
                begin
                    vdone = 1'b1;
                    nx    = fjot_pkg::PH_AFTER_VAL;
                end
                else
                begin
                    ob   = q_tok.raw;
                    kind = fjot_pkg::KIND_VALUE;
                end
            end
            fjot_pkg::PH_AFTER_VAL:
            begin
                if (q_tok.cls == fjot_pkg::CC_COMMA)
                    nx = fjot_pkg::PH_NEXT_KEY;
                else if (q_tok.cls == fjot_pkg::CC_CLOSE)
                    nx = fjot_pkg::PH_ACCEPTED;
                else if (q_tok.cls != fjot_pkg::CC_WS)
                    nx = fjot_pkg::PH_REJECTED;
            end
            fjot_pkg::PH_ACCEPTED:
            begin
                nx = fjot_pkg::PH_ACCEPTED;
            end
            default:
            begin
                nx = fjot_pkg::PH_REJECTED;
            end
        endcase

        if (nx == fjot_pkg::PH_ACCEPTED)
            status = fjot_pkg::ST_ACCEPTED;
        else if (nx == fjot_pkg::PH_REJECTED || q_tok.last)
            status = fjot_pkg::ST_REJECTED;
        else
            status = fjot_pkg::ST_RUNNING;

        phase_next = phase_reg;
        if (pop)
            phase_next = q_tok.last ? fjot_pkg::PH_WAIT_OPEN : nx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= fjot_pkg::PH_WAIT_OPEN;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (pop)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg   <= ob;
            kind_reg       <= kind;
            key_done_reg   <= kdone;
            value_done_reg <= vdone;
            status_reg     <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, status_reg, value_done_reg, key_done_reg, out_byte_reg};
    assign m_tuser  = kind_reg;

endmodule

// ----- design/flat_json_object_tokenizer_core.sv -----
// An input beat is registered in the token queue, then in the output register, before its result shows on m_tvalid.
// The core takes one beat per cycle unless m_tready holds back the output register, set by the parse state machine.
// A 2-entry token queue decouples the input from the output register.
// Reset (rst_n low, async) empties the queue, drops m_tvalid and returns the
// parser to waiting for the opening brace.
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer_core
// Validates a flat JSON object byte stream and emits decoded key/value bytes.
// ----------------------------------------------------------------------------
module flat_json_object_tokenizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_byte, [8] key_done, [9] value_done,
                                    // [11:10] status, [15:12] zero
    output logic [1:0]  m_tuser     // [1:0] byte_kind
);

    logic           push;
    fjot_pkg::tok_t push_tok;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    fjot_pkg::tok_t q_tok;

    fjot_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .push     (push),
        .push_tok (push_tok),
        .q_full   (q_full)
    );

    fjot_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_tok    (q_tok)
    );

    fjot_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_tok    (q_tok),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_no_content_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == fjot_pkg::KIND_NONE) |-> (m_tdata[7:0] == 8'h00))
        else $error("content byte without kind");

    a_done_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
        else $error("key and value done together");

    a_key_done_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> (m_tuser == fjot_pkg::KIND_NONE
                                      && m_tdata[11:10] != fjot_pkg::ST_ACCEPTED))
        else $error("key close carries content or accept");

    a_pop_needs_token: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule
